>>> src/tipf_pkg.sv
// Shared widths, register codes and control types of the temporal pixel filter.
package tipf_pkg;

  localparam int unsigned MAX_PIXELS  = 131072;
  localparam int unsigned PIXEL_BITS  = 16;
  localparam int unsigned IDX_BITS    = $clog2(MAX_PIXELS);
  localparam int unsigned CNT_BITS    = $clog2(MAX_PIXELS + 1);
  localparam int unsigned GAIN_FRAC   = 16;
  localparam int unsigned GAIN_BITS   = GAIN_FRAC + 1;
  localparam int unsigned PG_BITS     = PIXEL_BITS + GAIN_BITS;
  localparam int unsigned ACC_BITS    = PG_BITS + 1;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 18;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE   = GAIN_BITS'(1 << GAIN_FRAC);
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1 << (GAIN_FRAC - 1));
  localparam logic [CFG_DATA_BITS-1:0] FRAME_RESET = CFG_DATA_BITS'(76800);
  localparam logic [CNT_BITS-1:0] MAX_COUNT = CNT_BITS'(MAX_PIXELS);

  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN         = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_PIXELS = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic                last;
    logic                hv;
  } pix_ctl_t;

endpackage

>>> src/temporal_iir_pixel_filter_unit.sv
// Top level of the per-pixel temporal IIR filter with its history store and pipeline.
//
// Pixels enter in raster order on the input channel (in_valid_i, in_stall_o) and
// leave in the same order on the output channel (out_valid_o, out_stall_i). Each
// pixel gives one filtered value, old * (1 - gain) + new * gain truncated, and a
// flag on the last pixel of the frame. A request is taken at a clock edge where
// valid is high and stall is low.
// One pixel is accepted every cycle while in_stall_o is low. The history read is
// registered with stage a at the accepting edge, the new-sample product in stage b
// and the blend with the old value in stage c, which drives the output; the old
// value is forwarded when one of the two pixels ahead in the pipeline wrote the
// same history entry.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing is dropped or repeated.
// Reset sets gain to one half and the frame size to 76800. The history reads as
// zero after reset, after a clear request and after a change of frame size; a fill
// count marks the entries written since then, so no clearing pass is needed.
// Registers are written on the configuration channel (cfg_valid_i, cfg_ready_o),
// always ready; the user must do so only while the pipeline is empty, unenforced.
module temporal_iir_pixel_filter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tipf_pkg::PIXEL_BITS-1:0]     pixel_value_i,
  input  logic                                clear_history_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tipf_pkg::PIXEL_BITS-1:0]     filtered_value_o,
  output logic                                last_in_frame_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tipf_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [tipf_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  tipf_pkg::pix_ctl_t                ctl;
  logic [tipf_pkg::GAIN_BITS-1:0]    gain;
  logic [tipf_pkg::GAIN_BITS-1:0]    weight_old;
  logic                              adv, accept;

  logic [tipf_pkg::PIXEL_BITS-1:0]   hist_mem [tipf_pkg::MAX_PIXELS];
  logic [tipf_pkg::PIXEL_BITS-1:0]   rdata_q;

  logic                              a_vld_q, b_vld_q, c_vld_q;
  logic [tipf_pkg::PIXEL_BITS-1:0]   a_px_q;
  logic [tipf_pkg::IDX_BITS-1:0]     a_idx_q, b_idx_q, c_idx_q;
  logic                              a_last_q, b_last_q, c_last_q;
  logic                              a_hv_q, b_hv_q;
  logic [tipf_pkg::PG_BITS-1:0]      b_pg_q, b_pg_d;
  logic [tipf_pkg::PIXEL_BITS-1:0]   b_old_q, b_old_d;
  logic [tipf_pkg::PIXEL_BITS-1:0]   c_res_q, c_res_d;
  logic [tipf_pkg::PIXEL_BITS-1:0]   old_eff;
  logic [tipf_pkg::ACC_BITS-1:0]     acc;

  assign cfg_ready_o = 1'b1;
  assign adv         = !c_vld_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign accept      = in_valid_i && adv;

  tipf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .clear_i     (clear_history_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_o       (ctl),
    .gain_o      (gain)
  );

  assign weight_old = tipf_pkg::GAIN_ONE - gain;

  always_comb begin
    b_pg_d = tipf_pkg::PG_BITS'(a_px_q) * tipf_pkg::PG_BITS'(gain);
    if (!a_hv_q) begin
      b_old_d = '0;
    end else if (c_vld_q && (c_idx_q == a_idx_q)) begin
      b_old_d = c_res_q;
    end else begin
      b_old_d = rdata_q;
    end
  end

  always_comb begin
    old_eff = (b_hv_q && c_vld_q && (c_idx_q == b_idx_q)) ? c_res_q : b_old_q;
    acc     = tipf_pkg::ACC_BITS'(old_eff) * tipf_pkg::ACC_BITS'(weight_old)
            + tipf_pkg::ACC_BITS'(b_pg_q);
    c_res_d = acc[tipf_pkg::GAIN_FRAC +: tipf_pkg::PIXEL_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= hist_mem[ctl.idx];
    end
    if (adv && b_vld_q) begin
      hist_mem[b_idx_q] <= c_res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_px_q   <= pixel_value_i;
      a_idx_q  <= ctl.idx;
      a_last_q <= ctl.last;
      a_hv_q   <= ctl.hv;
      b_pg_q   <= b_pg_d;
      b_old_q  <= b_old_d;
      b_idx_q  <= a_idx_q;
      b_last_q <= a_last_q;
      b_hv_q   <= a_hv_q;
      c_res_q  <= c_res_d;
      c_idx_q  <= b_idx_q;
      c_last_q <= b_last_q;
    end
  end

  assign out_valid_o      = c_vld_q;
  assign filtered_value_o = c_res_q;
  assign last_in_frame_o  = c_last_q;

  a_clear_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && clear_history_i |=> a_idx_q == '0 && !a_hv_q)
    else $error("clear request did not restart at pixel zero");

  a_unwritten_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && a_vld_q && !a_hv_q |=> b_old_q == '0)
    else $error("unwritten history entry did not read as zero");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({a_vld_q, b_vld_q, c_vld_q}) && $stable(c_res_q))
    else $error("pipeline moved while the output was stalled");

endmodule

>>> src/tipf_seq.sv
// Configuration registers, raster position and history fill count of the pixel filter.
module tipf_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic                                 clear_i,
  input  logic                                 cfg_we_i,
  input  logic [tipf_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [tipf_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output tipf_pkg::pix_ctl_t                   ctl_o,
  output logic [tipf_pkg::GAIN_BITS-1:0]       gain_o
);

  logic [tipf_pkg::GAIN_BITS-1:0]     gain_q;
  logic [tipf_pkg::CFG_DATA_BITS-1:0] frame_q;
  logic [tipf_pkg::IDX_BITS-1:0]      pix_idx_q, pix_idx_d;
  logic [tipf_pkg::CNT_BITS-1:0]      fill_q, fill_d;
  logic [tipf_pkg::CNT_BITS-1:0]      frame_len, fill_eff;
  logic [tipf_pkg::IDX_BITS-1:0]      idx_raw, idx;
  logic [tipf_pkg::GAIN_BITS-1:0]     gain_wr;
  logic                               last, hv;

  always_comb begin
    if (frame_q == '0) begin
      frame_len = tipf_pkg::CNT_BITS'(1);
    end else if (tipf_pkg::CNT_BITS'(frame_q) > tipf_pkg::MAX_COUNT) begin
      frame_len = tipf_pkg::MAX_COUNT;
    end else begin
      frame_len = tipf_pkg::CNT_BITS'(frame_q);
    end
  end

  always_comb begin
    idx_raw  = clear_i ? '0 : pix_idx_q;
    fill_eff = clear_i ? '0 : fill_q;
    idx      = (tipf_pkg::CNT_BITS'(idx_raw) >= frame_len) ? '0 : idx_raw;
    last     = (tipf_pkg::CNT_BITS'(idx) == frame_len - tipf_pkg::CNT_BITS'(1));
    hv       = (tipf_pkg::CNT_BITS'(idx) < fill_eff);
    pix_idx_d = last ? '0 : idx + tipf_pkg::IDX_BITS'(1);
    fill_d    = hv ? fill_eff : tipf_pkg::CNT_BITS'(idx) + tipf_pkg::CNT_BITS'(1);
  end

  assign gain_wr = (cfg_data_i[tipf_pkg::GAIN_BITS-1:0] > tipf_pkg::GAIN_ONE) ?
                   tipf_pkg::GAIN_ONE : cfg_data_i[tipf_pkg::GAIN_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= tipf_pkg::GAIN_RESET;
      frame_q   <= tipf_pkg::FRAME_RESET;
      pix_idx_q <= '0;
      fill_q    <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == tipf_pkg::CFG_GAIN) begin
        gain_q <= gain_wr;
      end else if (cfg_index_i == tipf_pkg::CFG_FRAME_PIXELS) begin
        if (cfg_data_i != frame_q) begin
          frame_q   <= cfg_data_i;
          pix_idx_q <= '0;
          fill_q    <= '0;
        end
      end
    end else if (accept_i) begin
      pix_idx_q <= pix_idx_d;
      fill_q    <= fill_d;
    end
  end

  assign ctl_o.idx  = idx;
  assign ctl_o.last = last;
  assign ctl_o.hv   = hv;
  assign gain_o     = gain_q;

endmodule
